>>> hw/rtl/mscf_pkg.sv
// Shared types, constants and vertex tables for the filled marching-squares cell.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package mscf_pkg;

  localparam int IB        = 12;             // cell index width
  localparam int VB        = 32;             // sample and coordinate width
  localparam int SB        = 31;             // cell size width
  localparam int DW        = VB + 1;         // shifted sample magnitude width
  localparam int CW        = ((VB > IB + SB) ? VB : IB + SB) + 2;  // corner coordinate width
  localparam int MW        = SB + DW;        // size * magnitude product width
  localparam int QB        = SB + 1;         // quotient bits produced by the divider
  localparam int DIV_STEPS = QB / 2;         // two quotient bits a cycle
  localparam int CNT_W     = 4;              // covers DIV_STEPS and up to 15 vertices
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL       = 3'd0,
    CFG_ORIGIN_X    = 3'd1,
    CFG_ORIGIN_Y    = 3'd2,
    CFG_CELL_WIDTH  = 3'd3,
    CFG_CELL_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    V_LL  = 3'd0,
    V_LR  = 3'd1,
    V_UR  = 3'd2,
    V_UL  = 3'd3,
    V_BOT = 3'd4,
    V_RGT = 3'd5,
    V_TOP = 3'd6,
    V_LFT = 3'd7
  } vcode_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } bstate_e;

  typedef struct packed {
    logic        [IB-1:0] cell_col;
    logic        [IB-1:0] cell_row;
    logic signed [VB-1:0] sample_ll;
    logic signed [VB-1:0] sample_lr;
    logic signed [VB-1:0] sample_ur;
    logic signed [VB-1:0] sample_ul;
  } cell_t;

  typedef struct packed {
    logic signed [VB-1:0] vertex_x;
    logic signed [VB-1:0] vertex_y;
    logic                 last_of_cell;
  } res_t;

  // Classified cell handed from the front to the back.
  typedef struct packed {
    logic        [3:0]         cls;
    logic                      quad;
    logic signed [CW-1:0]      x_base;
    logic signed [CW-1:0]      y_base;
    logic        [3:0][DW-1:0] mag;   // |sample - level|, index LL, LR, UR, UL
  } entry_t;

  function automatic logic [3:0] fill_count(input logic [3:0] cls);
    logic [3:0] n;
    case (cls)
      4'd0:                               n = 4'd0;
      4'd1, 4'd2, 4'd4, 4'd8:             n = 4'd3;
      4'd7, 4'd11, 4'd13, 4'd14:          n = 4'd9;
      default:                            n = 4'd6;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] vert_count(input logic [3:0] cls, input logic quad);
    return quad ? fill_count(cls) + 4'd6 : fill_count(cls);
  endfunction

  function automatic vcode_e fill_code(input logic [3:0] cls, input logic [3:0] j);
    logic [26:0] seq;
    case (cls)
      4'd1:  seq = {V_LL, V_BOT, V_LFT, 18'd0};
      4'd2:  seq = {V_LR, V_RGT, V_BOT, 18'd0};
      4'd3:  seq = {V_LL, V_RGT, V_LFT, V_LL, V_LR, V_RGT, 9'd0};
      4'd4:  seq = {V_UR, V_TOP, V_RGT, 18'd0};
      4'd5:  seq = {V_LL, V_BOT, V_LFT, V_UR, V_TOP, V_RGT, 9'd0};
      4'd6:  seq = {V_BOT, V_UR, V_TOP, V_BOT, V_LR, V_UR, 9'd0};
      4'd7:  seq = {V_LL, V_LR, V_LFT, V_LFT, V_LR, V_TOP, V_LR, V_UR, V_TOP};
      4'd8:  seq = {V_UL, V_LFT, V_TOP, 18'd0};
      4'd9:  seq = {V_LL, V_TOP, V_UL, V_LL, V_BOT, V_TOP, 9'd0};
      4'd10: seq = {V_UL, V_LFT, V_TOP, V_LR, V_RGT, V_BOT, 9'd0};
      4'd11: seq = {V_LL, V_LR, V_RGT, V_LL, V_RGT, V_TOP, V_LL, V_TOP, V_UL};
      4'd12: seq = {V_LFT, V_UR, V_UL, V_LFT, V_RGT, V_UR, 9'd0};
      4'd13: seq = {V_LL, V_BOT, V_UL, V_UL, V_BOT, V_RGT, V_UL, V_RGT, V_UR};
      4'd14: seq = {V_BOT, V_LR, V_UR, V_BOT, V_UR, V_LFT, V_LFT, V_UR, V_UL};
      4'd15: seq = {V_LL, V_UR, V_UL, V_LL, V_LR, V_UR, 9'd0};
      default: seq = 27'd0;
    endcase
    return vcode_e'(seq[(4'd8 - j) * 3 +: 3]);
  endfunction

  // Saddle centre quad goes first, then the fixed triangulation.
  function automatic vcode_e vert_code(input logic [3:0] cls, input logic quad,
                                       input logic [3:0] k);
    vcode_e c;
    if (quad && k < 4'd6) begin
      case (k)
        4'd0:    c = V_BOT;
        4'd1:    c = V_RGT;
        4'd2:    c = V_TOP;
        4'd3:    c = V_BOT;
        4'd4:    c = V_TOP;
        default: c = V_LFT;
      endcase
    end else begin
      c = fill_code(cls, quad ? k - 4'd6 : k);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/mscf_front.sv
// Front end: classifies corners, forms the saddle decision and the cell origin.
// Depends on mscf_pkg.
`timescale 1ns / 1ps
module mscf_front import mscf_pkg::*; (
  input  logic                 start_i,
  input  logic                 full_i,
  input  cell_t                cell_i,
  input  logic signed [VB-1:0] level_i,
  input  logic signed [VB-1:0] origin_x_i,
  input  logic signed [VB-1:0] origin_y_i,
  input  logic        [SB-1:0] cell_width_i,
  input  logic        [SB-1:0] cell_height_i,
  output logic                 push_o,
  output entry_t               entry_o
);

  logic signed [3:0][DW-1:0] v;
  logic signed [DW+1:0]      sum;
  logic        [3:0]         cls;
  logic        [IB+SB-1:0]   px, py;

  always_comb begin
    v[0] = DW'($signed(cell_i.sample_ll)) - DW'(level_i);
    v[1] = DW'($signed(cell_i.sample_lr)) - DW'(level_i);
    v[2] = DW'($signed(cell_i.sample_ur)) - DW'(level_i);
    v[3] = DW'($signed(cell_i.sample_ul)) - DW'(level_i);
    sum  = '0;
    for (int i = 0; i < 4; i++) begin
      cls[i]        = !v[i][DW-1] && (v[i] != '0);
      sum           = sum + (DW+2)'($signed(v[i]));
      entry_o.mag[i] = v[i][DW-1] ? DW'(-v[i]) : DW'(v[i]);
    end
    px = (IB+SB)'(cell_i.cell_col) * (IB+SB)'(cell_width_i);
    py = (IB+SB)'(cell_i.cell_row) * (IB+SB)'(cell_height_i);
    entry_o.cls    = cls;
    entry_o.quad   = (cls == 4'd5 || cls == 4'd10) && (sum > 0);
    entry_o.x_base = CW'(origin_x_i) + $signed(CW'(px));
    entry_o.y_base = CW'(origin_y_i) + $signed(CW'(py));
    // Drop empty cells here: they produce no beat.
    push_o = start_i && !full_i && (cls != 4'd0);
  end

endmodule

>>> hw/rtl/mscf_queue.sv
// Small FIFO of classified cells between front and back.
// Depends on mscf_pkg.
`timescale 1ns / 1ps
module mscf_queue import mscf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t din_i,
  input  logic   pop_i,
  output entry_t dout_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ((wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? ((rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + NW'(push_i) - NW'(pop_i);
  end

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

>>> hw/rtl/mscf_div.sv
// Edge offset unit: floor(size * na / (na + nb)), two quotient bits a cycle.
// Depends on mscf_pkg.
`timescale 1ns / 1ps
module mscf_div import mscf_pkg::*; (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic          step_i,
  input  logic [SB-1:0] size_i,
  input  logic [DW-1:0] na_i,
  input  logic [DW-1:0] nb_i,
  output logic [SB-1:0] quo_o
);

  localparam int RW = DW + 1;

  logic [MW-1:0] prod;
  logic [RW-1:0] d_q, rem_q;
  logic [QB-1:0] low_q, quo_q;
  logic [RW:0]   r1, r2;
  logic [RW-1:0] s1, s2;
  logic          ge1, ge2;

  always_comb begin
    prod = MW'(size_i) * MW'(na_i);
    r1   = {rem_q, low_q[QB-1]};
    ge1  = r1 >= (RW+1)'(d_q);
    s1   = ge1 ? RW'(r1 - (RW+1)'(d_q)) : RW'(r1);
    r2   = {s1, low_q[QB-2]};
    ge2  = r2 >= (RW+1)'(d_q);
    s2   = ge2 ? RW'(r2 - (RW+1)'(d_q)) : RW'(r2);
    // Both ends at the level: offset is zero.
    quo_o = (d_q == '0) ? '0 : quo_q[SB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      // Quotient fits in QB bits, so the top of the product is already below d.
      rem_q <= RW'(prod[MW-1:QB]);
      low_q <= prod[QB-1:0];
      d_q   <= RW'(na_i) + RW'(nb_i);
      quo_q <= '0;
    end else if (step_i) begin
      rem_q <= s2;
      low_q <= {low_q[QB-3:0], 2'b00};
      quo_q <= {quo_q[QB-3:0], ge1, ge2};
    end
  end

endmodule

>>> hw/rtl/mscf_back.sv
// Back end: computes each edge offset and streams the triangle vertices.
// Depends on mscf_pkg and mscf_div.
`timescale 1ns / 1ps
module mscf_back import mscf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  entry_t        entry_i,
  input  logic [SB-1:0] cell_width_i,
  input  logic [SB-1:0] cell_height_i,
  output logic          pop_o,
  output logic          res_strobe_o,
  output res_t          res_o
);

  localparam logic signed [CW:0] VMAX = {{(CW-VB+2){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [CW:0] VMIN = {{(CW-VB+2){1'b1}}, {(VB-1){1'b0}}};

  bstate_e          state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  entry_t           ent_q;
  logic             load, step, emit, last;
  logic [3:0]       nvert;
  vcode_e           code;
  logic [SB-1:0]    off_bot, off_rgt, off_top, off_lft, offx, offy;
  logic signed [CW:0] xs, ys;
  logic             strobe_q;
  res_t             res_q;

  mscf_div u_div_bot (.clk_i, .load_i(load), .step_i(step), .size_i(cell_width_i),
    .na_i(entry_i.mag[0]), .nb_i(entry_i.mag[1]), .quo_o(off_bot));
  mscf_div u_div_rgt (.clk_i, .load_i(load), .step_i(step), .size_i(cell_height_i),
    .na_i(entry_i.mag[1]), .nb_i(entry_i.mag[2]), .quo_o(off_rgt));
  mscf_div u_div_top (.clk_i, .load_i(load), .step_i(step), .size_i(cell_width_i),
    .na_i(entry_i.mag[3]), .nb_i(entry_i.mag[2]), .quo_o(off_top));
  mscf_div u_div_lft (.clk_i, .load_i(load), .step_i(step), .size_i(cell_height_i),
    .na_i(entry_i.mag[0]), .nb_i(entry_i.mag[3]), .quo_o(off_lft));

  always_comb begin
    nvert = vert_count(ent_q.cls, ent_q.quad);
    code  = vert_code(ent_q.cls, ent_q.quad, cnt_q);
    last  = (cnt_q == nvert - 4'd1);
    state_d = state_q;
    cnt_d   = cnt_q;
    load    = 1'b0;
    step    = 1'b0;
    emit    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        step  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        emit  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          // Chain straight into the next queued cell.
          if (!empty_i) begin
            load    = 1'b1;
            cnt_d   = '0;
            state_d = B_DIV;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
    pop_o = load;

    case (code)
      V_LR, V_UR, V_RGT: offx = cell_width_i;
      V_BOT:             offx = off_bot;
      V_TOP:             offx = off_top;
      default:           offx = '0;
    endcase
    case (code)
      V_UR, V_UL, V_TOP: offy = cell_height_i;
      V_RGT:             offy = off_rgt;
      V_LFT:             offy = off_lft;
      default:           offy = '0;
    endcase
    xs = (CW+1)'(ent_q.x_base) + $signed((CW+1)'(offx));
    ys = (CW+1)'(ent_q.y_base) + $signed((CW+1)'(offy));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= entry_i;
    end
    if (emit) begin
      res_q.vertex_x     <= (xs > VMAX) ? VB'(VMAX) : (xs < VMIN) ? VB'(VMIN) : VB'(xs);
      res_q.vertex_y     <= (ys > VMAX) ? VB'(VMAX) : (ys < VMIN) ? VB'(VMIN) : VB'(ys);
      res_q.last_of_cell <= last;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

`ifndef ASSERT_OFF
  a_strobe_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q) == B_EMIT) else $error("beat outside emit");
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i) else $error("pop from empty queue");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> state_q == B_EMIT)
    else $error("divide did not end in emit");
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EMIT |-> cnt_q < nvert) else $error("vertex index past count");
`endif

endmodule

>>> hw/rtl/marching_squares_fill_cell.sv
// Top level of the filled marching-squares cell: configuration registers,
// front end, cell queue and back end. Depends on mscf_pkg and all mscf_* modules.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive cell_i and raise start_i; the cell is taken at a
//   rising edge where start_i is high and busy_o is low. busy_o is high only
//   while the cell queue is full.
//   Result channel: each beat is one triangle vertex on res_o, marked by
//   res_strobe_o for exactly one cycle; groups of three beats form a triangle
//   and last_of_cell flags the final beat of a cell. The receiver cannot stall.
//   Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
//   high; do so only while the block is idle.
//   Timing: a cell with no corner above the level is dropped in its accept
//   cycle and gives no beat. Other cells wait in the queue; the back end loads
//   the edge products, runs all edge dividers, then emits one vertex per
//   cycle (3 to 12 per cell). A queued cell is loaded in the cycle of the last
//   vertex of the one before, so the back end takes a new cell only as it
//   finishes the last. The divide and emit phases together set the throughput.
//   Reset: the control and configuration registers return to their reset
//   values, the queue empties and any cell in flight is lost.
module marching_squares_fill_cell import mscf_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  cell_t                cell_i,
  output logic                 res_strobe_o,
  output res_t                 res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic signed [VB-1:0] level_q, origin_x_q, origin_y_q;
  logic        [SB-1:0] cell_width_q, cell_height_q;
  logic                 push, pop, empty, full;
  entry_t               f_entry, q_entry;

  // Configuration registers; writes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= '0;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      cell_width_q  <= SB'(65536);
      cell_height_q <= SB'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEVEL:       level_q       <= VB'(cfg_data_i);
        CFG_ORIGIN_X:    origin_x_q    <= VB'(cfg_data_i);
        CFG_ORIGIN_Y:    origin_y_q    <= VB'(cfg_data_i);
        CFG_CELL_WIDTH:  cell_width_q  <= cfg_data_i[SB-1:0];
        CFG_CELL_HEIGHT: cell_height_q <= cfg_data_i[SB-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = full;

  // Classify at accept; only non-empty cells enter the queue.
  mscf_front u_front (
    .start_i       (start_i),
    .full_i        (full),
    .cell_i        (cell_i),
    .level_i       (level_q),
    .origin_x_i    (origin_x_q),
    .origin_y_i    (origin_y_q),
    .cell_width_i  (cell_width_q),
    .cell_height_i (cell_height_q),
    .push_o        (push),
    .entry_o       (f_entry)
  );

  mscf_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (f_entry),
    .pop_i   (pop),
    .dout_o  (q_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  // Divide, then stream vertices one beat a cycle.
  mscf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .entry_i       (q_entry),
    .cell_width_i  (cell_width_q),
    .cell_height_i (cell_height_q),
    .pop_o         (pop),
    .res_strobe_o  (res_strobe_o),
    .res_o         (res_o)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for marching_squares_fill_cell: directed cells, then
// random cells over several register settings. Depends on mscf_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import mscf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat in either direction
  localparam int DRAIN_CYCLES   = 48;    // longer than one cell in the back end
  localparam int ITEMS_PER_SET  = 26;    // random cells per register setting
  localparam logic signed [VB-1:0] ONE = 32'sd65536;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  cell_t       cell_i = '0;
  logic        res_strobe_o;
  res_t        res_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // Shadow copy of the configuration registers, kept in step with each write.
  logic signed [VB-1:0] level_r;
  logic signed [VB-1:0] origin_x_r;
  logic signed [VB-1:0] origin_y_r;
  logic        [SB-1:0] width_r;
  logic        [SB-1:0] height_r;

  res_t vertex_q[$];     // vertices still to come, oldest first
  int   error_count = 0;
  int   idle_cycles = 0;
  bit   no_gaps = 1'b0;  // run a stretch back to back

  marching_squares_fill_cell i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cell_i      (cell_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Clamp a wide coordinate to the signed output range.
  function automatic logic signed [VB-1:0] clamp_coord(input longint v);
    logic signed [VB-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[VB-1:0];
    return r;
  endfunction

  // Distance from the edge start to the crossing: floor(size*|a|/(|a|+|b|)).
  function automatic longint crossing_offset(input logic [SB-1:0] size,
                                             input longint va, input longint vb);
    logic [63:0] na;
    logic [63:0] nb;
    logic [63:0] q;
    na = (va < 0) ? -va : va;
    nb = (vb < 0) ? -vb : vb;
    if (na + nb == 64'd0) return 0;
    q = ({33'd0, size} * na) / (na + nb);
    return longint'(q);
  endfunction

  // Work out every vertex one cell emits and queue them in order.
  task automatic predict_fill(input cell_t c);
    longint v[4];
    longint sum;
    longint x, y, sx, sy;
    longint px[8];
    longint py[8];
    logic [3:0] cls;
    vcode_e seq[$];
    res_t r;
    v[0] = longint'(c.sample_ll) - longint'(level_r);
    v[1] = longint'(c.sample_lr) - longint'(level_r);
    v[2] = longint'(c.sample_ur) - longint'(level_r);
    v[3] = longint'(c.sample_ul) - longint'(level_r);
    sum = v[0] + v[1] + v[2] + v[3];
    for (int i = 0; i < 4; i++) cls[i] = (v[i] > 0);
    if (cls == 4'd0) return;  // empty cell: drop it
    sx = longint'({1'b0, width_r});
    sy = longint'({1'b0, height_r});
    x  = longint'(origin_x_r) + longint'({1'b0, c.cell_col}) * sx;
    y  = longint'(origin_y_r) + longint'({1'b0, c.cell_row}) * sy;
    px[V_LL]  = x;      py[V_LL]  = y;
    px[V_LR]  = x + sx; py[V_LR]  = y;
    px[V_UR]  = x + sx; py[V_UR]  = y + sy;
    px[V_UL]  = x;      py[V_UL]  = y + sy;
    px[V_BOT] = x + crossing_offset(width_r, v[0], v[1]);  py[V_BOT] = y;
    px[V_RGT] = x + sx; py[V_RGT] = y + crossing_offset(height_r, v[1], v[2]);
    px[V_TOP] = x + crossing_offset(width_r, v[3], v[2]);  py[V_TOP] = y + sy;
    px[V_LFT] = x;      py[V_LFT] = y + crossing_offset(height_r, v[0], v[3]);
    // A saddle whose shifted mean is positive gets the centre quad first.
    if ((cls == 4'd5 || cls == 4'd10) && sum > 0)
      seq = {V_BOT, V_RGT, V_TOP, V_BOT, V_TOP, V_LFT};
    case (cls)
      4'd1:  seq = {seq, V_LL, V_BOT, V_LFT};
      4'd2:  seq = {seq, V_LR, V_RGT, V_BOT};
      4'd3:  seq = {seq, V_LL, V_RGT, V_LFT, V_LL, V_LR, V_RGT};
      4'd4:  seq = {seq, V_UR, V_TOP, V_RGT};
      4'd5:  seq = {seq, V_LL, V_BOT, V_LFT, V_UR, V_TOP, V_RGT};
      4'd6:  seq = {seq, V_BOT, V_UR, V_TOP, V_BOT, V_LR, V_UR};
      4'd7:  seq = {seq, V_LL, V_LR, V_LFT, V_LFT, V_LR, V_TOP, V_LR, V_UR, V_TOP};
      4'd8:  seq = {seq, V_UL, V_LFT, V_TOP};
      4'd9:  seq = {seq, V_LL, V_TOP, V_UL, V_LL, V_BOT, V_TOP};
      4'd10: seq = {seq, V_UL, V_LFT, V_TOP, V_LR, V_RGT, V_BOT};
      4'd11: seq = {seq, V_LL, V_LR, V_RGT, V_LL, V_RGT, V_TOP, V_LL, V_TOP, V_UL};
      4'd12: seq = {seq, V_LFT, V_UR, V_UL, V_LFT, V_RGT, V_UR};
      4'd13: seq = {seq, V_LL, V_BOT, V_UL, V_UL, V_BOT, V_RGT, V_UL, V_RGT, V_UR};
      4'd14: seq = {seq, V_BOT, V_LR, V_UR, V_BOT, V_UR, V_LFT, V_LFT, V_UR, V_UL};
      default: seq = {seq, V_LL, V_UR, V_UL, V_LL, V_LR, V_UR};
    endcase
    foreach (seq[k]) begin
      r.vertex_x     = clamp_coord(px[seq[k]]);
      r.vertex_y     = clamp_coord(py[seq[k]]);
      r.last_of_cell = (k == seq.size() - 1);
      vertex_q.push_back(r);
    end
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one cell, hold it until taken, then idle for min_gap or more cycles.
  // A cell taken with a zero gap leaves start_i high for the next beat.
  task automatic send_cell(input cell_t c, input int min_gap, input int fixed_n);
    int gap;
    start_i <= 1'b1;
    cell_i  <= c;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    if (fixed_n == 0) begin
      // empty cell by inspection: nothing to queue
    end else if (fixed_n == 6) begin
      // full cell at the origin with reset registers
      vertex_q.push_back('{32'sd0, 32'sd0, 1'b0});
      vertex_q.push_back('{ONE, ONE, 1'b0});
      vertex_q.push_back('{32'sd0, ONE, 1'b0});
      vertex_q.push_back('{32'sd0, 32'sd0, 1'b0});
      vertex_q.push_back('{ONE, 32'sd0, 1'b0});
      vertex_q.push_back('{ONE, ONE, 1'b1});
    end else begin
      predict_fill(c);
    end
    gap = pick_gap();
    if (gap < min_gap) gap = min_gap;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Let every queued vertex drain, then give the back end time to settle.
  task automatic wait_idle();
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_LEVEL:      level_r    = data;
      CFG_ORIGIN_X:   origin_x_r = data;
      CFG_ORIGIN_Y:   origin_y_r = data;
      CFG_CELL_WIDTH: width_r    = data[SB-1:0];
      default:        height_r   = data[SB-1:0];
    endcase
  endtask

  // Write all five registers; the top bit of the size words is junk.
  task automatic write_all(input logic [31:0] lv, input logic [31:0] ox,
                           input logic [31:0] oy, input logic [30:0] w,
                           input logic [30:0] h);
    write_reg(CFG_LEVEL, lv);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_CELL_WIDTH, {1'($urandom_range(0, 1)), w});
    write_reg(CFG_CELL_HEIGHT, {1'($urandom_range(0, 1)), h});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sample near the level at a random scale, or anything at all.
  function automatic logic signed [VB-1:0] pick_sample(input bit near);
    longint s;
    if (!near) return $urandom;
    s = longint'(level_r) + (longint'($urandom_range(0, 16)) - 8) *
        longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
    return clamp_coord(s);
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    bit near;
    near = ($urandom_range(0, 9) < 7);
    c.cell_col  = IB'($urandom);
    c.cell_row  = IB'($urandom);
    c.sample_ll = pick_sample(near);
    c.sample_lr = pick_sample(near);
    c.sample_ur = pick_sample(near);
    c.sample_ul = pick_sample(near);
    return c;
  endfunction

  // Check each vertex beat against the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_strobe_o) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d last=%0b",
               res_o.vertex_x, res_o.vertex_y, res_o.last_of_cell);
        error_count++;
      end else begin
        want = vertex_q.pop_front();
        if (res_o.vertex_x !== want.vertex_x) begin
          $error("vertex_x expected %0d actual %0d", want.vertex_x, res_o.vertex_x);
          error_count++;
        end
        if (res_o.vertex_y !== want.vertex_y) begin
          $error("vertex_y expected %0d actual %0d", want.vertex_y, res_o.vertex_y);
          error_count++;
        end
        if (res_o.last_of_cell !== want.last_of_cell) begin
          $error("last_of_cell expected %0b actual %0b",
                 want.last_of_cell, res_o.last_of_cell);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without a beat on either channel.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_strobe_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL marching_squares_fill_cell");
      $finish;
    end
  end

  typedef struct {
    cell_t c;
    int    fixed_n;  // 0 or 6: typed expectation, -1: predicted
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    cell_t c;
    level_r    = '0;
    origin_x_r = '0;
    origin_y_r = '0;
    width_r    = 31'd65536;
    height_r   = 31'd65536;

    // Directed cells: extremes, every class, saddles both ways.
    dir_rows = '{
      '{'{12'd0, 12'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000}, 0},
      '{'{12'd5, 12'd7, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 0},
      '{'{12'd0, 12'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 6},
      '{'{12'd4095, 12'd4095, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff}, -1},
      '{'{12'd1, 12'd2, 32'sd100, -32'sd300, -32'sd1, -32'sd5}, -1},
      '{'{12'd3, 12'd1, -32'sd1, 32'sd70000, -32'sd9, -32'sd2}, -1},
      '{'{12'd2, 12'd2, -32'sd4, -32'sd4, 32'sd1, -32'sd4}, -1},
      '{'{12'd9, 12'd3, -32'sd1, -32'sd1, -32'sd1, 32'sh7fffffff}, -1},
      '{'{12'd1, 12'd1, 32'sd5, 32'sd6, -32'sd7, -32'sd8}, -1},
      '{'{12'd1, 12'd1, -32'sd5, 32'sd6, 32'sd7, -32'sd8}, -1},
      '{'{12'd1, 12'd1, -32'sd5, -32'sd6, 32'sd7, 32'sd8}, -1},
      '{'{12'd1, 12'd1, 32'sd5, -32'sd6, -32'sd7, 32'sd8}, -1},
      '{'{12'd0, 12'd4095, 32'sd9, 32'sd9, 32'sd9, 32'sh80000000}, -1},
      '{'{12'd4095, 12'd0, 32'sh80000000, 32'sd3, 32'sd3, 32'sd3}, -1},
      '{'{12'd7, 12'd7, 32'sd3, 32'sh80000000, 32'sd3, 32'sd3}, -1},
      '{'{12'd7, 12'd7, 32'sd3, 32'sd3, 32'sh80000000, 32'sd3}, -1},
      '{'{12'd8, 12'd8, 32'sd10, -32'sd1, 32'sd10, -32'sd1}, -1},
      '{'{12'd8, 12'd8, 32'sd10, -32'sd100, 32'sd10, -32'sd100}, -1},
      '{'{12'd8, 12'd8, -32'sd1, 32'sd10, -32'sd1, 32'sd10}, -1},
      '{'{12'd8, 12'd8, -32'sd100, 32'sd10, -32'sd100, 32'sd10}, -1},
      '{'{12'd8, 12'd8, 32'sd10, -32'sd10, 32'sd10, -32'sd10}, -1},
      '{'{12'd6, 12'd6, 32'sd1, 32'sd0, 32'sd0, 32'sd0}, -1}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed table under reset registers.
    foreach (dir_rows[i])
      send_cell(dir_rows[i].c, (i == dir_rows.size() - 1) ? 1 : 0, dir_rows[i].fixed_n);

    // Random cells, one batch per register setting.
    for (int set = 0; set < 5; set++) begin
      wait_idle();
      case (set)
        0: write_all(32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'd1);
        1: write_all(32'h7fffffff, 32'h80000000, 32'h80000000, 31'd0, 31'd0);
        2: write_all($urandom, $urandom, $urandom, 31'($urandom_range(1, 1 << 20)),
                     31'($urandom_range(1, 1 << 20)));
        3: write_all(32'h00000000, 32'h80000000, 32'h80000000, 31'd1, 31'h7fffffff);
        default: write_all($urandom_range(0, 1 << 18) - (1 << 17), $urandom, $urandom,
                           31'($urandom), 31'($urandom));
      endcase
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (n % 12 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        c = random_cell();
        send_cell(c, (n == ITEMS_PER_SET - 1) ? 1 : 0, -1);
      end
      no_gaps = 1'b0;
    end

    wait_idle();
    if (error_count == 0 && vertex_q.size() == 0) begin
      $display("PASS marching_squares_fill_cell");
    end else begin
      $display("FAIL marching_squares_fill_cell");
    end
    $finish;
  end

endmodule
